>>> design/ssb_pkg.sv
// Shared types, constants and register map for the scaled sprite blitter.
// No dependencies; every other design file but ssb_ram imports this package.
`default_nettype none

package ssb_pkg;

	// Screen and store geometry.
	localparam int STORE_DEPTH = 4096;
	localparam int SCREEN_COLS = 320;
	localparam int SCREEN_ROWS = 240;
	localparam int STORE_AW = $clog2(STORE_DEPTH);

	// Field widths.
	localparam int SRC_W = 8;    // source width and height
	localparam int BASE_W = 12;  // frame base and texel address
	localparam int POS_W = 11;   // signed destination position
	localparam int DST_W = 10;   // destination size and pixel counters
	localparam int PIX_W = 16;   // RGB565 texel
	localparam int FB_W = 17;    // framebuffer address
	localparam int SCR_W = POS_W + 1;

	localparam logic [PIX_W-1:0] KEY_COLOR = 16'hF81F;

	// Scaling divider: dividend is counter times source size, two bits per cycle.
	localparam int NUM_W = DST_W + SRC_W;
	localparam int DIV_CYCLES = NUM_W / 2;
	localparam int DIV_CNT_W = $clog2(DIV_CYCLES);

	// Store address reduction by reciprocal multiplication.
	localparam int PROD_W = 2 * SRC_W;
	localparam int SUM_W = 17;
	localparam int RED_SHIFT = SUM_W + STORE_AW;
	localparam int RECIP_W = SUM_W + 1;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(((64'd1 << RED_SHIFT)
		+ 64'(STORE_DEPTH) - 64'd1) / 64'(STORE_DEPTH));

	// APB register map.
	localparam int APB_AW = 5;
	localparam int APB_DW = 32;

	typedef enum logic [2:0] {
		REG_SRC_WIDTH,
		REG_SRC_HEIGHT,
		REG_FRAME_BASE,
		REG_DEST_X,
		REG_DEST_Y,
		REG_DEST_WIDTH,
		REG_DEST_HEIGHT,
		REG_MIRROR
	} reg_idx_t;

	typedef struct packed {
		logic [SRC_W-1:0] src_width;
		logic [SRC_W-1:0] src_height;
		logic [BASE_W-1:0] frame_base;
		logic signed [POS_W-1:0] dest_x;
		logic signed [POS_W-1:0] dest_y;
		logic [DST_W-1:0] dest_width;
		logic [DST_W-1:0] dest_height;
		logic mirror;
	} cfg_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic store_write;
		logic start;
		logic div_step;
		logic index;
		logic reduce;
		logic fetch;
		logic finish;
		logic finish_draw;
	} dp_cmd_t;

endpackage

`default_nettype wire

>>> design/ssb_in_if.sv
// Input channel of the blitter: valid/ready handshake with a load or draw word.
// Depends on ssb_pkg for field widths.
`default_nettype none

interface ssb_in_if
	import ssb_pkg::*;
;
	logic valid;
	logic ready;
	logic operation;
	logic [BASE_W-1:0] texel_address;
	logic [PIX_W-1:0] texel_value;

	modport source (output valid, operation, texel_address, texel_value, input ready);
	modport sink (input valid, operation, texel_address, texel_value, output ready);
endinterface

`default_nettype wire

>>> design/ssb_out_if.sv
// Output channel of the blitter: valid/ready handshake with a framebuffer write word.
// Depends on ssb_pkg for field widths.
`default_nettype none

interface ssb_out_if
	import ssb_pkg::*;
;
	logic valid;
	logic ready;
	logic write_enable;
	logic [FB_W-1:0] fb_address;
	logic [PIX_W-1:0] pixel;
	logic last;

	modport source (output valid, write_enable, fb_address, pixel, last, input ready);
	modport sink (input valid, write_enable, fb_address, pixel, last, output ready);
endinterface

`default_nettype wire

>>> design/ssb_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module ssb_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

`default_nettype wire

>>> design/ssb_regs.sv
// APB configuration register file of the blitter.
// Depends on ssb_pkg for the register map and the cfg_t structure.
`default_nettype none

module ssb_regs
	import ssb_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [APB_DW-1:0] pwdata,
	output      logic [APB_DW-1:0] prdata,
	output      logic              pready,
	output      cfg_t              cfg
);
	cfg_t cfg_q;
	reg_idx_t idx;

	assign idx = reg_idx_t'(paddr[APB_AW-1:2]);
	assign pready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.src_width <= SRC_W'(16);
			cfg_q.src_height <= SRC_W'(16);
			cfg_q.frame_base <= '0;
			cfg_q.dest_x <= '0;
			cfg_q.dest_y <= '0;
			cfg_q.dest_width <= '0;
			cfg_q.dest_height <= '0;
			cfg_q.mirror <= 1'b0;
		end else if (psel && penable && pwrite) begin
			case (idx)
				REG_SRC_WIDTH: cfg_q.src_width <= pwdata[SRC_W-1:0];
				REG_SRC_HEIGHT: cfg_q.src_height <= pwdata[SRC_W-1:0];
				REG_FRAME_BASE: cfg_q.frame_base <= pwdata[BASE_W-1:0];
				REG_DEST_X: cfg_q.dest_x <= pwdata[POS_W-1:0];
				REG_DEST_Y: cfg_q.dest_y <= pwdata[POS_W-1:0];
				REG_DEST_WIDTH: cfg_q.dest_width <= pwdata[DST_W-1:0];
				REG_DEST_HEIGHT: cfg_q.dest_height <= pwdata[DST_W-1:0];
				REG_MIRROR: cfg_q.mirror <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_SRC_WIDTH: prdata = APB_DW'(cfg_q.src_width);
			REG_SRC_HEIGHT: prdata = APB_DW'(cfg_q.src_height);
			REG_FRAME_BASE: prdata = APB_DW'(cfg_q.frame_base);
			REG_DEST_X: prdata = APB_DW'({cfg_q.dest_x});
			REG_DEST_Y: prdata = APB_DW'({cfg_q.dest_y});
			REG_DEST_WIDTH: prdata = APB_DW'(cfg_q.dest_width);
			REG_DEST_HEIGHT: prdata = APB_DW'(cfg_q.dest_height);
			REG_MIRROR: prdata = APB_DW'(cfg_q.mirror);
			default: prdata = '0;
		endcase
	end
endmodule

`default_nettype wire

>>> design/ssb_ctrl.sv
// Controller of the blitter: sequences one word at a time, a draw word through divide,
// index, address reduction, store fetch and output, a load word straight to output. Depends on ssb_pkg.
`default_nettype none

module ssb_ctrl
	import ssb_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	input  wire logic in_op,
	output      logic in_ready,
	input  wire logic out_ready,
	output      logic out_valid,
	output      dp_cmd_t cmd
);
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIVIDE,
		ST_INDEX,
		ST_REDUCE,
		ST_FETCH,
		ST_FINISH
	} state_t;

	state_t state_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic op_q;
	logic out_valid_q;
	logic accept;

	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign accept = in_valid && in_ready;

	always_comb begin
		cmd.store_write = accept && !in_op;
		cmd.start = accept && in_op;
		cmd.div_step = (state_q == ST_DIVIDE);
		cmd.index = (state_q == ST_INDEX);
		cmd.reduce = (state_q == ST_REDUCE);
		cmd.fetch = (state_q == ST_FETCH);
		cmd.finish = (state_q == ST_FINISH) && (!out_valid_q || out_ready);
		cmd.finish_draw = op_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			div_cnt_q <= '0;
			op_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// The output word is replaced only when it is empty or being taken.
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						op_q <= in_op;
						div_cnt_q <= '0;
						state_q <= in_op ? ST_DIVIDE : ST_FINISH;
					end
				end
				ST_DIVIDE: begin
					div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
					if (div_cnt_q == DIV_CNT_W'(DIV_CYCLES - 1)) begin
						state_q <= ST_INDEX;
					end
				end
				ST_INDEX: state_q <= ST_REDUCE;
				ST_REDUCE: state_q <= ST_FETCH;
				ST_FETCH: state_q <= ST_FINISH;
				ST_FINISH: begin
					if (cmd.finish) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

`default_nettype wire

>>> design/ssb_dpath.sv
// Datapath of the blitter: pixel counters, scaling dividers, store address
// arithmetic, texel store and output word register. Depends on ssb_pkg, ssb_ram.
`default_nettype none

module ssb_dpath
	import ssb_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cfg_t              cfg,
	input  wire dp_cmd_t           cmd,
	input  wire logic [BASE_W-1:0] texel_address,
	input  wire logic [PIX_W-1:0]  texel_value,
	output      logic              write_enable,
	output      logic [FB_W-1:0]   fb_address,
	output      logic [PIX_W-1:0]  pixel,
	output      logic              last
);
	typedef struct packed {
		logic [DST_W-1:0] rem;
		logic [NUM_W-1:0] num;
	} div_t;

	localparam int MUL_W = SUM_W + RECIP_W;
	localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(STORE_DEPTH);
	localparam logic [POS_W-1:0] COLS_L = POS_W'(SCREEN_COLS);
	localparam logic [POS_W-1:0] ROWS_L = POS_W'(SCREEN_ROWS);

	// One restoring division step; the quotient bit shifts in where the dividend leaves.
	function automatic div_t div_step(div_t cur, logic [DST_W-1:0] d);
		div_t nxt;
		logic [DST_W:0] rs;
		rs = {cur.rem, cur.num[NUM_W-1]};
		if (rs >= {1'b0, d}) begin
			rs = rs - {1'b0, d};
			nxt.num = {cur.num[NUM_W-2:0], 1'b1};
		end else begin
			nxt.num = {cur.num[NUM_W-2:0], 1'b0};
		end
		nxt.rem = rs[DST_W-1:0];
		return nxt;
	endfunction

	logic [DST_W-1:0] column_q, row_q;
	div_t div_x_q, div_y_q;
	logic [SRC_W-1:0] sx_q;
	logic [PROD_W-1:0] prod_q;
	logic on_screen_q;
	logic [FB_W-1:0] fb_q;
	logic [SUM_W-1:0] sum_q, quot_q;
	logic out_we_q, out_last_q;
	logic [FB_W-1:0] out_fb_q;
	logic [PIX_W-1:0] out_pixel_q;

	logic [SRC_W-1:0] sw, sh, sx_clamp, sx, sy;
	logic [DST_W-1:0] dw, dh;
	logic [SCR_W-1:0] scr_x, scr_y;
	logic [SUM_W-1:0] sum, rem;
	logic [MUL_W-1:0] recip_prod;
	logic [STORE_AW-1:0] raddr;
	logic [PIX_W-1:0] texel;
	logic [DST_W:0] col_next, row_next;
	logic end_col, end_row, draw_we;

	always_comb begin
		sw = (cfg.src_width == '0) ? SRC_W'(1) : cfg.src_width;
		sh = (cfg.src_height == '0) ? SRC_W'(1) : cfg.src_height;
		dw = (cfg.dest_width == '0) ? DST_W'(sw) : cfg.dest_width;
		dh = (cfg.dest_height == '0) ? DST_W'(sh) : cfg.dest_height;

		// Quotients are clamped to the last source texel.
		sx_clamp = (div_x_q.num >= NUM_W'(sw)) ? sw - SRC_W'(1) : div_x_q.num[SRC_W-1:0];
		sx = cfg.mirror ? sw - SRC_W'(1) - sx_clamp : sx_clamp;
		sy = (div_y_q.num >= NUM_W'(sh)) ? sh - SRC_W'(1) : div_y_q.num[SRC_W-1:0];

		scr_x = {cfg.dest_x[POS_W-1], cfg.dest_x} + SCR_W'(column_q);
		scr_y = {cfg.dest_y[POS_W-1], cfg.dest_y} + SCR_W'(row_q);

		sum = SUM_W'(cfg.frame_base) + SUM_W'(prod_q) + SUM_W'(sx_q);
		recip_prod = MUL_W'(sum) * MUL_W'(RECIP);
		rem = sum_q - SUM_W'(quot_q * DEPTH_S);
		raddr = STORE_AW'(rem);

		col_next = {1'b0, column_q} + (DST_W + 1)'(1);
		row_next = {1'b0, row_q} + (DST_W + 1)'(1);
		end_col = col_next >= {1'b0, dw};
		end_row = row_next >= {1'b0, dh};
		draw_we = on_screen_q && (texel != KEY_COLOR);
	end

	ssb_ram #(
		.WIDTH(PIX_W),
		.DEPTH(STORE_DEPTH)
	) u_store (
		.clk(clk),
		.we(cmd.store_write),
		.waddr(STORE_AW'(texel_address)),
		.wdata(texel_value),
		.re(cmd.fetch),
		.raddr(raddr),
		.rdata(texel)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q <= '0;
			row_q <= '0;
		end else if (cmd.finish && cmd.finish_draw) begin
			if (end_col) begin
				column_q <= '0;
				row_q <= end_row ? '0 : row_next[DST_W-1:0];
			end else begin
				column_q <= col_next[DST_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			div_x_q.num <= NUM_W'(column_q) * NUM_W'(sw);
			div_x_q.rem <= '0;
			div_y_q.num <= NUM_W'(row_q) * NUM_W'(sh);
			div_y_q.rem <= '0;
		end else if (cmd.div_step) begin
			div_x_q <= div_step(div_step(div_x_q, dw), dw);
			div_y_q <= div_step(div_step(div_y_q, dh), dh);
		end

		if (cmd.index) begin
			sx_q <= sx;
			prod_q <= PROD_W'(sy) * PROD_W'(sw);
			on_screen_q <= !scr_x[SCR_W-1] && (scr_x[POS_W-1:0] < COLS_L)
				&& !scr_y[SCR_W-1] && (scr_y[POS_W-1:0] < ROWS_L);
			fb_q <= FB_W'(scr_y[POS_W-1:0]) * FB_W'(COLS_L) + FB_W'(scr_x[POS_W-1:0]);
		end

		if (cmd.reduce) begin
			sum_q <= sum;
			quot_q <= SUM_W'(recip_prod >> RED_SHIFT);
		end

		if (cmd.finish) begin
			if (cmd.finish_draw) begin
				out_we_q <= draw_we;
				out_fb_q <= draw_we ? fb_q : '0;
				out_pixel_q <= draw_we ? texel : '0;
				out_last_q <= end_col && end_row;
			end else begin
				out_we_q <= 1'b0;
				out_fb_q <= '0;
				out_pixel_q <= '0;
				out_last_q <= 1'b0;
			end
		end
	end

	assign write_enable = out_we_q;
	assign fb_address = out_fb_q;
	assign pixel = out_pixel_q;
	assign last = out_last_q;
endmodule

`default_nettype wire

>>> design/scaled_sprite_blitter.sv
// Scaled sprite blitter: nearest-neighbor scaled, chroma-keyed copy of a sprite frame.
// Usage: an APB port sets the frame size, base, destination rectangle and mirror.
// Each word on in_ch either loads one texel into the 4096-entry sprite store
// (operation 0) or draws the next destination pixel in row-major order
// (operation 1). Every input word gives exactly one word on out_ch: a load gives
// an all-zero word; a draw gives write_enable, fb_address and pixel for a
// framebuffer write, or write_enable low for keyed texels and off-screen pixels,
// and last on the rectangle's final pixel.
// Sequencing: a draw word passes through the scaling dividers, which retire two
// quotient bits of the 18-bit dividend per cycle, then through the index, address
// reduction, store read and output stages; a load word goes straight to output.
// A new word is accepted only after the last one's result has entered the
// output register. The result is valid the cycle after its last stage and
// waits in the output register while the receiver stalls; a further word can
// be accepted meanwhile but its result waits for that register.
// Reset clears the pixel counters and loads the register defaults; the sprite
// store is not cleared and must be loaded before it is drawn from.
// Depends on ssb_pkg, ssb_in_if, ssb_out_if, ssb_regs, ssb_ctrl and ssb_dpath.
`default_nettype none

module scaled_sprite_blitter
	import ssb_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [APB_DW-1:0] pwdata,
	output      logic [APB_DW-1:0] prdata,
	output      logic              pready,
	ssb_in_if.sink                 in_ch,
	ssb_out_if.source              out_ch
);
	cfg_t cfg;
	dp_cmd_t cmd;
	logic in_ready, out_valid;

	ssb_regs u_regs (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.cfg(cfg)
	);

	ssb_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_ch.valid),
		.in_op(in_ch.operation),
		.in_ready(in_ready),
		.out_ready(out_ch.ready),
		.out_valid(out_valid),
		.cmd(cmd)
	);

	ssb_dpath u_dpath (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.cmd(cmd),
		.texel_address(in_ch.texel_address),
		.texel_value(in_ch.texel_value),
		.write_enable(out_ch.write_enable),
		.fb_address(out_ch.fb_address),
		.pixel(out_ch.pixel),
		.last(out_ch.last)
	);

	assign in_ch.ready = in_ready;
	assign out_ch.valid = out_valid;
endmodule

`default_nettype wire

>>> tb/ssb_tb_pkg.sv
`timescale 1ns / 1ps
// Testbench types for the scaled sprite blitter: the load and draw codes of an
// input word and the layout of one result word. Depends on ssb_pkg for widths.

package ssb_tb_pkg;
	import ssb_pkg::*;

	typedef enum logic {
		OP_LOAD,
		OP_DRAW
	} blit_op_t;

	typedef struct packed {
		logic             write_enable;
		logic [FB_W-1:0]  fb_address;
		logic [PIX_W-1:0] pixel;
		logic             last;
	} fb_word_t;

endpackage

>>> tb/ssb_pixel_checker.sv
`timescale 1ns / 1ps
// Result checker for the scaled sprite blitter: snoops APB writes and both channels,
// predicts every result word and compares it field by field with the block's output.
// Depends on ssb_pkg, ssb_tb_pkg, ssb_in_if and ssb_out_if.

module ssb_pixel_checker
	import ssb_pkg::*;
	import ssb_tb_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic              pready,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	ssb_in_if                 in_mon,
	ssb_out_if                out_mon,
	output int                failures,
	output int                pending,
	output int                pixels_written,
	output int                rects_done
);

	cfg_t settings;
	logic [PIX_W-1:0] texel_mem [STORE_DEPTH];
	logic [DST_W-1:0] column;
	logic [DST_W-1:0] row;
	fb_word_t awaited_words [$];

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected 'h%0h, got 'h%0h", name, want, got);
			failures++;
		end
	endfunction

	// Works out the word for the current destination pixel and advances the walk.
	function automatic fb_word_t predict_draw();
		int unsigned sw, sh, dw, dh, sx, sy, col, rw;
		int scr_x, scr_y;
		logic [PIX_W-1:0] texel;
		logic end_col, end_row;
		fb_word_t w;
		w = '0;
		sw = (settings.src_width == 0) ? 1 : settings.src_width;
		sh = (settings.src_height == 0) ? 1 : settings.src_height;
		dw = (settings.dest_width == 0) ? sw : settings.dest_width;
		dh = (settings.dest_height == 0) ? sh : settings.dest_height;
		col = column;
		rw = row;
		sx = col * sw / dw;
		if (sx >= sw)
			sx = sw - 1;
		if (settings.mirror)
			sx = sw - 1 - sx;
		sy = rw * sh / dh;
		if (sy >= sh)
			sy = sh - 1;
		texel = texel_mem[STORE_AW'((settings.frame_base + sy * sw + sx) % STORE_DEPTH)];
		scr_x = $signed(settings.dest_x) + int'(col);
		scr_y = $signed(settings.dest_y) + int'(rw);
		if (scr_x >= 0 && scr_x < SCREEN_COLS && scr_y >= 0 && scr_y < SCREEN_ROWS
				&& texel != KEY_COLOR) begin
			w.write_enable = 1'b1;
			w.fb_address = FB_W'(scr_y * SCREEN_COLS + scr_x);
			w.pixel = texel;
		end
		end_col = (col + 1 >= dw);
		end_row = (rw + 1 >= dh);
		w.last = end_col && end_row;
		if (end_col) begin
			column = '0;
			row = end_row ? '0 : DST_W'(rw + 1);
		end else begin
			column = DST_W'(col + 1);
		end
		return w;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		fb_word_t got;
		fb_word_t want;
		if (!arst_n) begin
			settings = '{src_width: SRC_W'(16), src_height: SRC_W'(16), default: '0};
			column = '0;
			row = '0;
			awaited_words.delete();
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[APB_AW-1:2]))
					REG_SRC_WIDTH:   settings.src_width = pwdata[SRC_W-1:0];
					REG_SRC_HEIGHT:  settings.src_height = pwdata[SRC_W-1:0];
					REG_FRAME_BASE:  settings.frame_base = pwdata[BASE_W-1:0];
					REG_DEST_X:      settings.dest_x = pwdata[POS_W-1:0];
					REG_DEST_Y:      settings.dest_y = pwdata[POS_W-1:0];
					REG_DEST_WIDTH:  settings.dest_width = pwdata[DST_W-1:0];
					REG_DEST_HEIGHT: settings.dest_height = pwdata[DST_W-1:0];
					REG_MIRROR:      settings.mirror = pwdata[0];
					default: ;
				endcase
			end
			// Results are retired before new words are queued, since a word accepted
			// at this edge cannot have produced its result yet.
			if (out_mon.valid && out_mon.ready) begin
				got = '{write_enable: out_mon.write_enable, fb_address: out_mon.fb_address,
					pixel: out_mon.pixel, last: out_mon.last};
				if (awaited_words.size() == 0) begin
					$error("result word arrived with no load or draw waiting for it");
					failures++;
				end else begin
					want = awaited_words.pop_front();
					check_field("write_enable", 32'(want.write_enable), 32'(got.write_enable));
					check_field("fb_address", 32'(want.fb_address), 32'(got.fb_address));
					check_field("pixel", 32'(want.pixel), 32'(got.pixel));
					check_field("last", 32'(want.last), 32'(got.last));
					if (want.write_enable)
						pixels_written++;
					if (want.last)
						rects_done++;
				end
			end
			if (in_mon.valid && in_mon.ready) begin
				if (in_mon.operation == OP_LOAD) begin
					texel_mem[in_mon.texel_address] = in_mon.texel_value;
					awaited_words.push_back('0);
				end else begin
					awaited_words.push_back(predict_draw());
				end
			end
		end
		pending = awaited_words.size();
	end

endmodule

>>> tb/tb_scaled_sprite_blitter.sv
`timescale 1ns / 1ps
// Testbench top for the scaled sprite blitter: clock, reset, APB register writes,
// texel loads and draw steps under idle and stall phases, and the verdict.
// Depends on ssb_pkg, ssb_tb_pkg, ssb_in_if, ssb_out_if and ssb_pixel_checker.

module tb_scaled_sprite_blitter;
	import ssb_pkg::*;
	import ssb_tb_pkg::*;

	localparam int RANDOM_PHASES = 12;
	localparam int QUIET_LIMIT = 5000;
	localparam int SETTLE_CYCLES = 20;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic pready;

	ssb_in_if in_ch();
	ssb_out_if out_ch();

	int failures;
	int pending;
	int pixels_written;
	int rects_done;
	int send_idle_pct;
	int recv_stall_pct;
	int quiet_cycles;
	int loads_sent;
	int draws_sent;
	int settings_applied;
	bit texel_loaded [STORE_DEPTH];

	scaled_sprite_blitter u_top (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	ssb_pixel_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.pready(pready),
		.paddr(paddr),
		.pwdata(pwdata),
		.in_mon(in_ch),
		.out_mon(out_ch),
		.failures(failures),
		.pending(pending),
		.pixels_written(pixels_written),
		.rects_done(rects_done)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("[scaled_sprite_blitter] ERROR");
			$finish;
		end
	end

	task automatic reg_write(reg_idx_t idx, logic [APB_DW-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apply_settings(cfg_t c);
		reg_write(REG_SRC_WIDTH, APB_DW'(c.src_width));
		reg_write(REG_SRC_HEIGHT, APB_DW'(c.src_height));
		reg_write(REG_FRAME_BASE, APB_DW'(c.frame_base));
		reg_write(REG_DEST_X, APB_DW'($signed(c.dest_x)));
		reg_write(REG_DEST_Y, APB_DW'($signed(c.dest_y)));
		reg_write(REG_DEST_WIDTH, APB_DW'(c.dest_width));
		reg_write(REG_DEST_HEIGHT, APB_DW'(c.dest_height));
		reg_write(REG_MIRROR, APB_DW'(c.mirror));
		settings_applied++;
	endtask

	// Returns at the edge that accepts the word, with valid still high.
	task automatic send_word(blit_op_t op, logic [BASE_W-1:0] addr, logic [PIX_W-1:0] value);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.operation <= op;
		in_ch.texel_address <= addr;
		in_ch.texel_value <= value;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		if (op == OP_LOAD) begin
			texel_loaded[addr] = 1'b1;
			loads_sent++;
		end else begin
			draws_sent++;
		end
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	function automatic logic [PIX_W-1:0] random_texel();
		return ($urandom_range(3) == 0) ? KEY_COLOR : PIX_W'($urandom);
	endfunction

	function automatic int unsigned random_src_size();
		case ($urandom_range(15))
			0: return 0;
			1: return (1 << SRC_W) - 1;
			default: return 1 + $urandom_range(15);
		endcase
	endfunction

	function automatic logic [DST_W-1:0] random_dest_size();
		case ($urandom_range(15))
			0, 1: return '0;
			2: return DST_W'(1);
			3: return '1;
			default: return DST_W'(1 + $urandom_range(19));
		endcase
	endfunction

	function automatic logic signed [POS_W-1:0] random_pos(int span);
		case ($urandom_range(9))
			0: return POS_W'(-(1 << (POS_W - 1)));
			1: return POS_W'((1 << (POS_W - 1)) - 1);
			default: return POS_W'(int'($urandom_range(span + 40)) - 20);
		endcase
	endfunction

	function automatic cfg_t random_settings();
		cfg_t c;
		int unsigned sw, sh;
		sw = random_src_size();
		sh = random_src_size();
		// Keep the frame small enough that loading all of it stays cheap.
		if (((sw == 0) ? 1 : sw) * ((sh == 0) ? 1 : sh) > 600)
			sh = 1 + $urandom_range(1);
		c.src_width = SRC_W'(sw);
		c.src_height = SRC_W'(sh);
		c.frame_base = BASE_W'($urandom);
		c.dest_x = random_pos(SCREEN_COLS);
		c.dest_y = random_pos(SCREEN_ROWS);
		c.dest_width = random_dest_size();
		c.dest_height = random_dest_size();
		c.mirror = 1'($urandom_range(1));
		return c;
	endfunction

	initial begin
		cfg_t c;
		int unsigned steps;
		int unsigned frame_texels;
		logic [BASE_W-1:0] a;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		in_ch.valid <= 1'b0;
		in_ch.operation <= OP_LOAD;
		in_ch.texel_address <= '0;
		in_ch.texel_value <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// A mirrored two by two frame that wraps past the end of the store, stretched
		// to three by three and hanging off the top left corner of the screen.
		c = '{src_width: SRC_W'(2), src_height: SRC_W'(2),
			frame_base: BASE_W'(STORE_DEPTH - 2), dest_x: POS_W'(-1),
			dest_y: POS_W'(-1), dest_width: DST_W'(3), dest_height: DST_W'(3),
			mirror: 1'b1};
		apply_settings(c);
		send_word(OP_LOAD, BASE_W'(STORE_DEPTH - 2), 16'hFFFF);
		send_word(OP_LOAD, BASE_W'(STORE_DEPTH - 1), KEY_COLOR);
		send_word(OP_LOAD, '0, 16'h0000);
		send_word(OP_LOAD, BASE_W'(1), 16'h5A5A);
		repeat (9) send_word(OP_DRAW, '1, '1);
		drain();

		// Zero sizes everywhere: a single texel copied unscaled to the bottom right pixel.
		c = '{src_width: '0, src_height: '0, frame_base: BASE_W'(STORE_DEPTH - 1),
			dest_x: POS_W'(SCREEN_COLS - 1), dest_y: POS_W'(SCREEN_ROWS - 1),
			dest_width: '0, dest_height: '0, mirror: 1'b0};
		apply_settings(c);
		send_word(OP_LOAD, BASE_W'(STORE_DEPTH - 1), 16'hABCD);
		repeat (2) send_word(OP_DRAW, '0, '0);
		drain();

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			case (ph % 4)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 76;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 76;
				end
				default: begin
					send_idle_pct = 33;
					recv_stall_pct = 33;
				end
			endcase
			c = random_settings();
			apply_settings(c);
			// Every texel the frame can reach is loaded before any draw step reads it.
			frame_texels = ((c.src_width == 0) ? 1 : c.src_width)
				* ((c.src_height == 0) ? 1 : c.src_height);
			for (int unsigned k = 0; k < frame_texels; k++) begin
				a = BASE_W'(c.frame_base + k);
				if (!texel_loaded[a])
					send_word(OP_LOAD, a, random_texel());
			end
			steps = 50 + $urandom_range(40);
			repeat (steps) begin
				if ($urandom_range(99) < 12)
					send_word(OP_LOAD, BASE_W'($urandom), random_texel());
				else
					send_word(OP_DRAW, BASE_W'($urandom), PIX_W'($urandom));
			end
			drain();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Sent %0d texel loads and %0d draw steps under %0d register settings.",
			loads_sent, draws_sent, settings_applied);
		$display("Checked %0d framebuffer writes and %0d completed rectangles.",
			pixels_written, rects_done);
		if (failures == 0)
			$display("[scaled_sprite_blitter] OK");
		else
			$display("[scaled_sprite_blitter] ERROR");
		$finish;
	end

endmodule
